/* sv/gsc_pkg.sv */
// Shared types and constants for the glyph slot cache.
// No dependencies; imported by every module of the block.
package gsc_pkg;

    localparam int TABLE_ENTRIES = 512;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int USED_W        = IDX_W + 1;
    localparam int CODE_W        = 21;
    localparam int COLOR_W       = 4;
    localparam int DIM_W         = 8;
    localparam int COORD_W       = 16;
    localparam int SRC_W         = IDX_W + DIM_W;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = QPTR_W + 1;

    localparam logic [COLOR_W-1:0] FORE_RESET = COLOR_W'(7);
    localparam logic [COLOR_W-1:0] BACK_RESET = COLOR_W'(0);
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = DIM_W'(8);
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = DIM_W'(16);

    // Register byte addresses
    localparam int                 PADDR_W       = 3;
    localparam logic [PADDR_W-1:0] ADDR_CELL_WIDTH  = PADDR_W'(0);
    localparam logic [PADDR_W-1:0] ADDR_CELL_HEIGHT = PADDR_W'(4);

    // One classified character cell, queued from front to back
    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic               recolor;
        logic               refill;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
    } t_work;

    // One glyph table entry
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  slot;
        logic [CODE_W-1:0] code;
    } t_entry;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

endpackage

/* sv/gsc_front.sv */
// Front end: resolves colors, tracks current colors, hashes the code point
// and computes destination coordinates. Depends on gsc_pkg.
module gsc_front
    import gsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_cell_row,
    input  logic [7:0]         i_cell_column,
    input  logic [CODE_W-1:0]  i_code_point,
    input  logic [COLOR_W-1:0] i_fore_index,
    input  logic [COLOR_W-1:0] i_back_index,
    input  logic               i_reverse_video,
    input  logic               i_cursor_here,
    input  logic               i_bold_text,
    input  logic [DIM_W-1:0]   i_cell_width,
    input  logic [DIM_W-1:0]   i_cell_height,
    input  logic               i_clearing,
    input  t_qstat             i_qstat,
    output logic               o_push,
    output t_work              o_work
);

    logic [COLOR_W-1:0] r_cur_fore, n_cur_fore;
    logic [COLOR_W-1:0] r_cur_back, n_cur_back;
    logic [COLOR_W-1:0] swap_fore;
    logic [COLOR_W-1:0] swap_back;
    logic               swap;

    assign o_stall = i_qstat.full | i_clearing;
    assign o_push  = i_valid & ~o_stall;

    always_comb begin
        swap      = i_reverse_video ^ i_cursor_here;
        swap_fore = swap ? i_back_index : i_fore_index;
        swap_back = swap ? i_fore_index : i_back_index;
        // bold lifts a normal foreground into the intense half
        n_cur_fore = (i_bold_text && !swap_fore[COLOR_W-1])
                   ? {1'b1, swap_fore[COLOR_W-2:0]} : swap_fore;
        n_cur_back = swap_back;

        o_work.code    = i_code_point;
        o_work.idx     = {|i_code_point[CODE_W-1:8], i_code_point[7:0]};
        o_work.fore    = n_cur_fore;
        o_work.back    = n_cur_back;
        o_work.recolor = (n_cur_fore != r_cur_fore);
        o_work.refill  = (n_cur_fore != r_cur_fore) || (n_cur_back != r_cur_back);
        o_work.dest_x  = COORD_W'(i_cell_column) * COORD_W'(i_cell_width);
        o_work.dest_y  = COORD_W'(i_cell_row) * COORD_W'(i_cell_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_fore <= FORE_RESET;
            r_cur_back <= BACK_RESET;
        end else if (o_push) begin
            r_cur_fore <= n_cur_fore;
            r_cur_back <= n_cur_back;
        end
    end

`ifndef SYNTHESIS
    a_no_push_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clearing |-> !o_push)
        else $error("word taken during table clear");
`endif

endmodule

/* sv/gsc_queue.sv */
// Short FIFO between front and back ends, holding classified words.
// Depends on gsc_pkg.
module gsc_queue
    import gsc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_work  i_data,
    input  logic   i_pop,
    output t_work  o_head,
    output t_qstat o_stat
);

    t_work              r_data [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_head       = r_data[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.full && !i_pop) |-> !i_push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("queue underflow");
`endif

endmodule

/* sv/gsc_back.sv */
// Back end: glyph table lookup and update, slot allocation, output register.
// Holds the 512-entry table memory. Depends on gsc_pkg.
module gsc_back
    import gsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_work              i_head,
    input  t_qstat             i_qstat,
    output logic               o_pop,
    output logic               o_clearing,
    input  logic [DIM_W-1:0]   i_cell_width,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [IDX_W-1:0]   o_glyph_slot,
    output logic               o_glyph_miss,
    output logic [COLOR_W-1:0] o_eff_fore,
    output logic [COLOR_W-1:0] o_eff_back,
    output logic               o_recolor_strokes,
    output logic               o_refill_background,
    output logic [USED_W-1:0]  o_slots_in_use,
    output logic [SRC_W-1:0]   o_source_x,
    output logic [COORD_W-1:0] o_dest_x,
    output logic [COORD_W-1:0] o_dest_y
);

    t_entry             r_mem [TABLE_ENTRIES];
    t_entry             r_rd_data;
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_clr_addr;
    logic [USED_W-1:0]  r_next_free;
    t_work              r_work;
    logic               r_out_valid;

    logic               out_free;
    logic               hit;
    logic               alloc;
    logic [IDX_W-1:0]   slot;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry             mem_wdata;

    assign out_free   = !r_out_valid || !i_stall;
    assign o_pop      = (r_state == S_IDLE) && !i_qstat.empty && out_free;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_out_valid;

    always_comb begin
        hit   = r_rd_data.valid && (r_rd_data.code == r_work.code);
        alloc = !r_rd_data.valid;
        slot  = r_rd_data.valid ? r_rd_data.slot : r_next_free[IDX_W-1:0];

        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_LOOK: begin
                mem_we          = !hit;
                mem_waddr       = r_work.idx;
                mem_wdata.valid = 1'b1;
                mem_wdata.slot  = slot;
                mem_wdata.code  = r_work.code;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase

        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[i_head.idx];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_head;
        end
        if (r_state == S_LOOK) begin
            o_glyph_slot        <= slot;
            o_glyph_miss        <= !hit;
            o_eff_fore          <= r_work.fore;
            o_eff_back          <= r_work.back;
            o_recolor_strokes   <= r_work.recolor;
            o_refill_background <= r_work.refill;
            o_slots_in_use      <= r_next_free;
            o_source_x          <= SRC_W'(slot) * SRC_W'(i_cell_width);
            o_dest_x            <= r_work.dest_x;
            o_dest_y            <= r_work.dest_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_next_free <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_LOOK && alloc && !r_next_free[USED_W-1]) begin
                r_next_free <= r_next_free + 1'b1;
            end
            if (r_state == S_LOOK) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_slot_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= USED_W'(TABLE_ENTRIES))
        else $error("slot count beyond table size");
    a_out_free_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> !r_out_valid)
        else $error("result overwritten while waiting");
    a_alloc_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && alloc && !r_next_free[USED_W-1])
        |=> r_next_free == $past(r_next_free) + 1'b1)
        else $error("allocation did not advance free slot");
`endif

endmodule

/* sv/glyph_slot_cache_with_color_state_core.sv */
// Top level of the glyph slot cache with color tracking.
// Instantiates gsc_front, gsc_queue, gsc_back; depends on gsc_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall): one character cell per word, taken at
//   a rising edge with i_valid high and o_stall low. Output channel
//   (o_valid / i_stall): one result word per input word, in order.
//   The front end resolves colors and compares them with the current pair
//   at acceptance, then queues the word (two-entry queue). The back end
//   reads the glyph table entry (registered read), then decides hit, miss
//   or allocation, rewrites the entry on a miss and loads the output register.
//   An accepted word passes through the queue, the registered table read and
//   the output register. A new word is popped only after the last one has done
//   its read-modify-write (read, decide/write) on the single table memory.
//   Reset: i_rst_n is synchronous, active low. After reset the back end
//   sweeps the 512 table entries to invalid, one per cycle; o_stall is high
//   during the sweep. Config writes are taken at any time.
//   Receiver stall: the result holds in the output register; the queue
//   keeps taking words until full, then o_stall rises.
//   Config: APB-style, cell width at address 0, cell height at address 4;
//   write only while the block is idle.
module glyph_slot_cache_with_color_state_core
    import gsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_cell_row,
    input  logic [7:0]         i_cell_column,
    input  logic [CODE_W-1:0]  i_code_point,
    input  logic [COLOR_W-1:0] i_fore_index,
    input  logic [COLOR_W-1:0] i_back_index,
    input  logic               i_reverse_video,
    input  logic               i_cursor_here,
    input  logic               i_bold_text,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [IDX_W-1:0]   o_glyph_slot,
    output logic               o_glyph_miss,
    output logic [COLOR_W-1:0] o_eff_fore,
    output logic [COLOR_W-1:0] o_eff_back,
    output logic               o_recolor_strokes,
    output logic               o_refill_background,
    output logic [USED_W-1:0]  o_slots_in_use,
    output logic [SRC_W-1:0]   o_source_x,
    output logic [COORD_W-1:0] o_dest_x,
    output logic [COORD_W-1:0] o_dest_y
);

    logic [DIM_W-1:0] r_cell_width;
    logic [DIM_W-1:0] r_cell_height;
    logic             cfg_wr;
    logic             q_push;
    logic             q_pop;
    logic             clearing;
    t_work            q_in;
    t_work            q_head;
    t_qstat           q_stat;

    // APB: zero wait states; decode by word address, ignore the byte lanes
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width  <= WIDTH_RESET;
            r_cell_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            priority if (paddr[PADDR_W-1] == ADDR_CELL_WIDTH[PADDR_W-1]) begin
                r_cell_width <= pwdata[DIM_W-1:0];
            end else if (paddr[PADDR_W-1] == ADDR_CELL_HEIGHT[PADDR_W-1]) begin
                r_cell_height <= pwdata[DIM_W-1:0];
            end
        end
    end

    always_comb begin
        priority if (paddr[PADDR_W-1] == ADDR_CELL_WIDTH[PADDR_W-1]) begin
            prdata = {{(32-DIM_W){1'b0}}, r_cell_width};
        end else begin
            prdata = {{(32-DIM_W){1'b0}}, r_cell_height};
        end
    end

    gsc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cell_row      (i_cell_row),
        .i_cell_column   (i_cell_column),
        .i_code_point    (i_code_point),
        .i_fore_index    (i_fore_index),
        .i_back_index    (i_back_index),
        .i_reverse_video (i_reverse_video),
        .i_cursor_here   (i_cursor_here),
        .i_bold_text     (i_bold_text),
        .i_cell_width    (r_cell_width),
        .i_cell_height   (r_cell_height),
        .i_clearing      (clearing),
        .i_qstat         (q_stat),
        .o_push          (q_push),
        .o_work          (q_in)
    );

    gsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    gsc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head              (q_head),
        .i_qstat             (q_stat),
        .o_pop               (q_pop),
        .o_clearing          (clearing),
        .i_cell_width        (r_cell_width),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_glyph_slot        (o_glyph_slot),
        .o_glyph_miss        (o_glyph_miss),
        .o_eff_fore          (o_eff_fore),
        .o_eff_back          (o_eff_back),
        .o_recolor_strokes   (o_recolor_strokes),
        .o_refill_background (o_refill_background),
        .o_slots_in_use      (o_slots_in_use),
        .o_source_x          (o_source_x),
        .o_dest_x            (o_dest_x),
        .o_dest_y            (o_dest_y)
    );

endmodule

/* verif/tb_glyph_slot_cache_with_color_state_core.sv */
// Self-checking testbench for glyph_slot_cache_with_color_state_core.
// Drives character words and APB register writes, predicts each result word in place.
// Depends on gsc_pkg and the core RTL only.
module tb_glyph_slot_cache_with_color_state_core
    import gsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_WORDS   = 496;
    localparam int DIRECTED_ROWS = 17;
    localparam int RECENT_DEPTH  = 16;

    // One character word as the sender presents it
    typedef struct packed {
        logic [7:0]         row;
        logic [7:0]         column;
        logic [CODE_W-1:0]  code;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic               reverse;
        logic               cursor;
        logic               bold;
    } t_char_word;

    // One result word, field for field as it leaves the block
    typedef struct packed {
        logic [IDX_W-1:0]   slot;
        logic               miss;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic               recolor;
        logic               refill;
        logic [USED_W-1:0]  used;
        logic [SRC_W-1:0]   source_x;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
    } t_glyph_result;

    // A directed row; 'fixed' marks a result typed in by hand
    typedef struct packed {
        t_char_word    word;
        logic          fixed;
        t_glyph_result res;
    } t_directed_row;

    // Directed rows run at the reset cell size (8 x 16) on a cold table.
    localparam t_directed_row DIRECTED [DIRECTED_ROWS] = '{
        // cold table: code point zero allocates slot 0, reset colors unchanged
        '{'{8'd0, 8'd0, 21'h000000, 4'd7, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{9'd0, 1'b1, 4'd7, 4'd0, 1'b0, 1'b0, 10'd0, 17'd0, 16'd0, 16'd0}},
        // hit on the same code point, farthest cell position
        '{'{8'd255, 8'd255, 21'h000000, 4'd7, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{9'd0, 1'b0, 4'd7, 4'd0, 1'b0, 1'b0, 10'd1, 17'd0, 16'd2040, 16'd4080}},
        // highest code point, brightest colors
        '{'{8'd0, 8'd0, 21'h10FFFF, 4'd15, 4'd15, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{9'd1, 1'b1, 4'd15, 4'd15, 1'b1, 1'b1, 10'd1, 17'd8, 16'd0, 16'd0}},
        // collision: same low byte, reuse the slot without allocating
        '{'{8'd0, 8'd0, 21'h0001FF, 4'd15, 4'd15, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{9'd1, 1'b1, 4'd15, 4'd15, 1'b0, 1'b0, 10'd2, 17'd8, 16'd0, 16'd0}},
        // collide back, reverse video swaps the pair
        '{'{8'd0, 8'd0, 21'h10FFFF, 4'd3, 4'd12, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{9'd1, 1'b1, 4'd12, 4'd3, 1'b1, 1'b1, 10'd2, 17'd8, 16'd0, 16'd0}},
        // reverse under the cursor cancels out, bold lifts 3 to 11
        '{'{8'd0, 8'd0, 21'h0000FF, 4'd3, 4'd12, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{9'd2, 1'b1, 4'd11, 4'd12, 1'b1, 1'b1, 10'd2, 17'd16, 16'd0, 16'd0}},
        // cursor alone swaps, then bold lifts the swapped foreground
        '{'{8'd0, 8'd0, 21'h000100, 4'd9, 4'd5, 1'b0, 1'b1, 1'b1}, 1'b1,
          '{9'd3, 1'b1, 4'd13, 4'd9, 1'b1, 1'b1, 10'd3, 17'd24, 16'd0, 16'd0}},
        // bold leaves an intense foreground alone
        '{'{8'd0, 8'd0, 21'h000100, 4'd8, 4'd9, 1'b0, 1'b0, 1'b1}, 1'b1,
          '{9'd3, 1'b0, 4'd8, 4'd9, 1'b1, 1'b1, 10'd4, 17'd24, 16'd0, 16'd0}},
        // background change only: refill without recolor
        '{'{8'd0, 8'd0, 21'h000001, 4'd8, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{9'd4, 1'b1, 4'd8, 4'd0, 1'b0, 1'b1, 10'd4, 17'd32, 16'd0, 16'd0}},
        // bold on the top normal color
        '{'{8'd1, 8'd1, 21'h000000, 4'd7, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b1,
          '{9'd0, 1'b0, 4'd15, 4'd0, 1'b1, 1'b1, 10'd5, 17'd0, 16'd8, 16'd16}},
        // bold on color zero
        '{'{8'd1, 8'd1, 21'h000000, 4'd0, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b1,
          '{9'd0, 1'b0, 4'd8, 4'd0, 1'b1, 1'b1, 10'd5, 17'd0, 16'd8, 16'd16}},
        // alternating bit patterns and code points past the Unicode range
        '{'{8'hAA, 8'h55, 21'h155555, 4'hA, 4'h5, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h55, 8'hAA, 21'h0AAAAA, 4'h5, 4'hA, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{8'd255, 8'd0, 21'h1FFFFF, 4'd15, 4'd0, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{8'd0, 8'd255, 21'h1FFF00, 4'd0, 4'd15, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{8'd255, 8'd0, 21'h1FFFFF, 4'd15, 4'd0, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{8'd128, 8'd128, 21'h0000FF, 4'd7, 4'd7, 1'b1, 1'b0, 1'b1}, 1'b0, '0}
    };

    // Clock, reset and block pins; every input starts at a known value
    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_cell_row      = '0;
    logic [7:0]         i_cell_column   = '0;
    logic [CODE_W-1:0]  i_code_point    = '0;
    logic [COLOR_W-1:0] i_fore_index    = '0;
    logic [COLOR_W-1:0] i_back_index    = '0;
    logic               i_reverse_video = 1'b0;
    logic               i_cursor_here   = 1'b0;
    logic               i_bold_text     = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [IDX_W-1:0]   o_glyph_slot;
    logic               o_glyph_miss;
    logic [COLOR_W-1:0] o_eff_fore;
    logic [COLOR_W-1:0] o_eff_back;
    logic               o_recolor_strokes;
    logic               o_refill_background;
    logic [USED_W-1:0]  o_slots_in_use;
    logic [SRC_W-1:0]   o_source_x;
    logic [COORD_W-1:0] o_dest_x;
    logic [COORD_W-1:0] o_dest_y;

    // Sideband that travels with the word: a hand-typed result, if any
    logic          fixed_flag   = 1'b0;
    t_glyph_result fixed_result = '0;

    // Mirror of the block's state, advanced once per accepted word
    logic              entry_valid [TABLE_ENTRIES] = '{default: 1'b0};
    logic [IDX_W-1:0]  entry_slot  [TABLE_ENTRIES] = '{default: '0};
    logic [CODE_W-1:0] entry_code  [TABLE_ENTRIES] = '{default: '0};
    logic [USED_W-1:0]  slots_allocated = '0;
    logic [COLOR_W-1:0] shown_fore      = FORE_RESET;
    logic [COLOR_W-1:0] shown_back      = BACK_RESET;
    logic [DIM_W-1:0]   width_shadow    = WIDTH_RESET;
    logic [DIM_W-1:0]   height_shadow   = HEIGHT_RESET;

    t_glyph_result     pending_glyphs [$];
    logic [CODE_W-1:0] recent_codes [$];
    t_char_word        last_word   = '0;
    int unsigned       sweep_pos   = 0;
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       send_gap_pct   = 0;
    int unsigned       recv_stall_pct = 0;

    glyph_slot_cache_with_color_state_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_cell_row(i_cell_row), .i_cell_column(i_cell_column),
        .i_code_point(i_code_point), .i_fore_index(i_fore_index),
        .i_back_index(i_back_index), .i_reverse_video(i_reverse_video),
        .i_cursor_here(i_cursor_here), .i_bold_text(i_bold_text),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_glyph_slot(o_glyph_slot), .o_glyph_miss(o_glyph_miss),
        .o_eff_fore(o_eff_fore), .o_eff_back(o_eff_back),
        .o_recolor_strokes(o_recolor_strokes),
        .o_refill_background(o_refill_background),
        .o_slots_in_use(o_slots_in_use), .o_source_x(o_source_x),
        .o_dest_x(o_dest_x), .o_dest_y(o_dest_y)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: stall at random with the current pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Resolve colors, look the glyph up and advance the mirrored state.
    function automatic t_glyph_result resolve_glyph(input t_char_word w);
        t_glyph_result    r;
        logic [IDX_W-1:0] idx;
        r = '0;
        // reverse and cursor cancel each other out
        if (w.reverse != w.cursor) begin
            r.fore = w.back;
            r.back = w.fore;
        end else begin
            r.fore = w.fore;
            r.back = w.back;
        end
        if (w.bold && r.fore <= COLOR_W'(7))
            r.fore = r.fore + COLOR_W'(8);
        r.recolor  = (r.fore != shown_fore);
        r.refill   = r.recolor || (r.back != shown_back);
        r.used     = slots_allocated;
        shown_fore = r.fore;
        shown_back = r.back;

        // Latin-1 maps to itself, everything else to its low byte in the upper half
        idx = (w.code <= CODE_W'(8'hFF)) ? {1'b0, w.code[7:0]} : {1'b1, w.code[7:0]};
        if (entry_valid[idx]) begin
            r.slot = entry_slot[idx];
            r.miss = (entry_code[idx] != w.code);
        end else begin
            r.slot = slots_allocated[IDX_W-1:0];
            if (slots_allocated < USED_W'(TABLE_ENTRIES))
                slots_allocated = slots_allocated + 1'b1;
            r.miss = 1'b1;
        end
        if (r.miss) begin
            entry_valid[idx] = 1'b1;
            entry_slot[idx]  = r.slot;
            entry_code[idx]  = w.code;
        end

        r.source_x = SRC_W'(r.slot) * SRC_W'(width_shadow);
        r.dest_x   = COORD_W'(w.column) * COORD_W'(width_shadow);
        r.dest_y   = COORD_W'(w.row) * COORD_W'(height_shadow);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Scoreboard: push the prediction on input acceptance, then compare any result
    // word accepted at the same edge against the oldest one.
    always @(posedge i_clk) begin : scoreboard
        t_char_word    seen;
        t_glyph_result want;
        t_glyph_result got;
        if (i_rst_n) begin
            if (i_valid && o_stall === 1'b0) begin
                seen = '{i_cell_row, i_cell_column, i_code_point, i_fore_index,
                         i_back_index, i_reverse_video, i_cursor_here, i_bold_text};
                want = resolve_glyph(seen);
                // hand-typed rows override the prediction, the mirror still advances
                if (fixed_flag)
                    want = fixed_result;
                pending_glyphs.push_back(want);
            end
            if (o_valid === 1'b1 && !i_stall) begin
                got = '{o_glyph_slot, o_glyph_miss, o_eff_fore, o_eff_back,
                        o_recolor_strokes, o_refill_background, o_slots_in_use,
                        o_source_x, o_dest_x, o_dest_y};
                if (pending_glyphs.size() == 0) begin
                    error_count++;
                    $display("%0t: result word with nothing expected, slot %0d",
                             $time, got.slot);
                end else begin
                    want = pending_glyphs.pop_front();
                    check_field("glyph_slot", want.slot, got.slot);
                    check_field("glyph_miss", want.miss, got.miss);
                    check_field("eff_fore", want.fore, got.fore);
                    check_field("eff_back", want.back, got.back);
                    check_field("recolor_strokes", want.recolor, got.recolor);
                    check_field("refill_background", want.refill, got.refill);
                    check_field("slots_in_use", want.used, got.used);
                    check_field("source_x", want.source_x, got.source_x);
                    check_field("dest_x", want.dest_x, got.dest_x);
                    check_field("dest_y", want.dest_y, got.dest_y);
                end
            end
        end
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_glyph_slot_cache_with_color_state_core failed");
            $finish;
        end
    end

    // One APB transfer: setup, access, wait for pready; keep the shadow registers
    // in step with writes at the edge the block takes them.
    task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        if (write) begin
            if (addr == ADDR_CELL_WIDTH)
                width_shadow = data[DIM_W-1:0];
            else if (addr == ADDR_CELL_HEIGHT)
                height_shadow = data[DIM_W-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input logic [PADDR_W-1:0] addr, input logic [DIM_W-1:0] want);
        logic [31:0] rdata;
        apb_access(1'b0, addr, '0, rdata);
        if (rdata !== {24'd0, want}) begin
            error_count++;
            $display("%0t: register %0d expected %0d, got %0d", $time, addr, want, rdata);
        end
    endtask

    // Write a register with junk in the upper bits, then read it back.
    task automatic set_register(input logic [PADDR_W-1:0] addr, input logic [DIM_W-1:0] value);
        logic [31:0] rdata;
        apb_access(1'b1, addr, {24'($urandom), value}, rdata);
        check_register(addr, value);
    endtask

    // Present one word, idling first at random; return at its acceptance edge.
    task automatic send_word(input t_char_word w, input logic fixed,
                             input t_glyph_result res);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_cell_row      <= w.row;
        i_cell_column   <= w.column;
        i_code_point    <= w.code;
        i_fore_index    <= w.fore;
        i_back_index    <= w.back;
        i_reverse_video <= w.reverse;
        i_cursor_here   <= w.cursor;
        i_bold_text     <= w.bold;
        fixed_flag      <= fixed;
        fixed_result    <= res;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // Hold the sender until every expected result word has come back.
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_glyphs.size() != 0);
    endtask

    // Random word: a sweep over every table index until the table is full (drives
    // slot exhaustion), repeats of recent code points for hits, low-byte
    // collisions, and stray code points. Colors often repeat the last word so
    // that unchanged-color cases stay common.
    function automatic t_char_word make_word();
        t_char_word        w;
        int unsigned       pick;
        logic [CODE_W-1:0] cp;
        w    = last_word;
        pick = $urandom_range(99);
        if (sweep_pos < TABLE_ENTRIES && pick < 50) begin
            if (sweep_pos < 256)
                cp = CODE_W'(sweep_pos);
            else
                cp = {13'($urandom_range(1, 'h10F)), 8'(sweep_pos - 256)};
            sweep_pos++;
        end else if (pick < 75 && recent_codes.size() != 0) begin
            cp = recent_codes[$urandom_range(recent_codes.size() - 1)];
        end else if (pick < 85 && recent_codes.size() != 0) begin
            cp = {13'($urandom_range(1, 'h10F)),
                  recent_codes[$urandom_range(recent_codes.size() - 1)][7:0]};
        end else if (pick < 90) begin
            cp = CODE_W'($urandom_range(0, 'h1FFFFF));
        end else begin
            cp = CODE_W'($urandom_range(0, 'h10FFFF));
        end
        w.code = cp;
        recent_codes.push_back(cp);
        if (recent_codes.size() > RECENT_DEPTH)
            void'(recent_codes.pop_front());

        if ($urandom_range(99) < 60) begin
            w.fore    = COLOR_W'($urandom);
            w.back    = COLOR_W'($urandom);
            w.reverse = 1'($urandom);
            w.cursor  = 1'($urandom);
            w.bold    = 1'($urandom);
        end
        if ($urandom_range(9) == 0) begin
            w.row    = $urandom_range(1) ? 8'd255 : 8'd0;
            w.column = $urandom_range(1) ? 8'd255 : 8'd0;
        end else begin
            w.row    = 8'($urandom);
            w.column = 8'($urandom);
        end
        last_word = w;
        return w;
    endfunction

    initial begin : stimulus
        int unsigned phase;
        int unsigned n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values read back while the table sweep runs
        check_register(ADDR_CELL_WIDTH, WIDTH_RESET);
        check_register(ADDR_CELL_HEIGHT, HEIGHT_RESET);

        send_gap_pct   = 6;
        recv_stall_pct = 47;
        for (n = 0; n < DIRECTED_ROWS; n++)
            send_word(DIRECTED[n].word, DIRECTED[n].fixed, DIRECTED[n].res);

        // Phases: widest cells, tallest cells, zero size, then a random size;
        // pressure swaps sides after the first phase and drops after the second.
        for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    set_register(ADDR_CELL_WIDTH, 8'd255);
                    set_register(ADDR_CELL_HEIGHT, 8'd1);
                end
                1: begin
                    set_register(ADDR_CELL_WIDTH, 8'd1);
                    set_register(ADDR_CELL_HEIGHT, 8'd255);
                    send_gap_pct   = 47;
                    recv_stall_pct = 6;
                end
                2: begin
                    set_register(ADDR_CELL_WIDTH, 8'd0);
                    set_register(ADDR_CELL_HEIGHT, 8'd0);
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
                default: begin
                    set_register(ADDR_CELL_WIDTH, 8'($urandom_range(1, 255)));
                    set_register(ADDR_CELL_HEIGHT, 8'($urandom_range(1, 255)));
                end
            endcase
            for (n = 0; n < PHASE_WORDS; n++) begin
                send_word(make_word(), 1'b0, '0);
                // now and then let the pipeline run dry mid-phase
                if ($urandom_range(149) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        // allow for a stray extra word after the last expected one
        repeat (12) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_glyph_slot_cache_with_color_state_core passed");
        else
            $display("tb_glyph_slot_cache_with_color_state_core failed");
        $finish;
    end

endmodule
